/* rtl/core/mkd_pkg.sv */
// shared types and constants for the morse key decoder
// no dependencies
package mkd_pkg;

    localparam int TICK_W              = 16;
    localparam int CFG_ADDR_W          = 2;
    localparam int CFG_DATA_W          = 16;
    localparam int CHAR_W              = 7;
    localparam int SYM_LEN_W           = 3;
    localparam int MAX_SYMBOLS_DEFAULT = 5;

    localparam logic [TICK_W-1:0] TICK_SAT       = {TICK_W{1'b1}};
    localparam logic [TICK_W-1:0] DOT_MIN_RESET  = 16'd7;
    localparam logic [TICK_W-1:0] DOT_MAX_RESET  = 16'(49 * 10);
    localparam logic [TICK_W-1:0] DASH_MAX_RESET = 16'(98 * 10);

    localparam logic [CFG_ADDR_W-1:0] REG_DOT_MIN  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_DOT_MAX  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_DASH_MAX = 2'd2;

    typedef enum logic [2:0] {
        EV_NONE    = 3'd0,
        EV_DOT     = 3'd1,
        EV_DASH    = 3'd2,
        EV_CHAR    = 3'd3,
        EV_UNKNOWN = 3'd4
    } event_kind_t;

    typedef struct packed {
        event_kind_t            kind;
        logic [CHAR_W-1:0]      char_code;
    } result_t;

endpackage

/* rtl/core/morse_key_decoder.sv */
// morse key decoder top level: key state, symbol collection and output skid stage
// depends on mkd_pkg and mkd_char_rom
// the result of each input transfer is registered into the output stage; one result per input
// throughput: one input per cycle while the skid entry is empty, set by the registered state update
// a two-entry output stage keeps input ready while one result waits
// reset (aresetn low, synchronous) clears key state and outputs, loads default thresholds
module morse_key_decoder import mkd_pkg::*; #(
    parameter int MAX_SYMBOLS = MAX_SYMBOLS_DEFAULT
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,  // [0] key_level
    input  logic                  s_axis_tuser,  // [0] op
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [7:0]            m_axis_tdata,  // [6:0] char_code
    output logic [2:0]            m_axis_tuser   // [2:0] event_kind
);

    logic [TICK_W-1:0] dot_min_reg, dot_max_reg, dash_max_reg;

    logic [TICK_W-1:0]      tick_reg, tick_next;
    logic [MAX_SYMBOLS-1:0] sym_bits_reg, sym_bits_next;
    logic [SYM_LEN_W-1:0]   sym_len_reg, sym_len_next;
    logic                   too_long_reg, too_long_next;
    logic                   key_down_reg, key_down_next;
    logic                   closed_reg, closed_next;

    result_t out_reg, skid_reg, res_next;
    logic    out_valid_reg, skid_valid_reg;

    logic              in_fire, out_fire;
    logic              op, level;
    logic [TICK_W-1:0] tick_inc;
    logic              is_dot, is_dash, gap;
    logic [CHAR_W-1:0] rom_char, lookup_char;

    assign op       = s_axis_tuser;
    assign level    = s_axis_tdata[0];
    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_fire = out_valid_reg && m_axis_tready;

    assign s_axis_tready = !skid_valid_reg;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_reg.char_code};
    assign m_axis_tuser  = out_reg.kind;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dot_min_reg  <= DOT_MIN_RESET;
            dot_max_reg  <= DOT_MAX_RESET;
            dash_max_reg <= DASH_MAX_RESET;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_DOT_MIN:  dot_min_reg  <= cfg_wdata;
                REG_DOT_MAX:  dot_max_reg  <= cfg_wdata;
                REG_DASH_MAX: dash_max_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    mkd_char_rom #(
        .MAX_SYMBOLS(MAX_SYMBOLS)
    ) u_rom (
        .sym_len  (sym_len_reg),
        .sym_bits (sym_bits_reg),
        .char_code(rom_char)
    );

    assign lookup_char = (too_long_reg || sym_len_reg == '0) ? '0 : rom_char;
    assign tick_inc    = (tick_reg == TICK_SAT) ? tick_reg : tick_reg + 1'b1;
    assign is_dot      = (tick_reg <= dot_max_reg) && (tick_reg >= dot_min_reg);
    assign is_dash     = !is_dot && (tick_reg <= dash_max_reg) && (tick_reg >= dot_max_reg);
    assign gap         = (tick_inc > dash_max_reg) && !key_down_reg && !closed_reg;

    always_comb begin
        tick_next          = tick_reg;
        sym_bits_next      = sym_bits_reg;
        sym_len_next       = sym_len_reg;
        too_long_next      = too_long_reg;
        key_down_next      = key_down_reg;
        closed_next        = closed_reg;
        res_next.kind      = EV_NONE;
        res_next.char_code = '0;
        if (op) begin
            tick_next = '0;
            if (level) begin
                key_down_next = 1'b1;
                closed_next   = 1'b0;
            end else begin
                key_down_next = 1'b0;
                if (is_dot || is_dash) begin
                    res_next.kind = is_dot ? EV_DOT : EV_DASH;
                    closed_next   = 1'b0;
                    if (sym_len_reg >= SYM_LEN_W'(MAX_SYMBOLS)) begin
                        too_long_next = 1'b1;
                    end else begin
                        sym_bits_next = {sym_bits_reg[MAX_SYMBOLS-2:0], is_dash};
                        sym_len_next  = sym_len_reg + 1'b1;
                    end
                end
            end
        end else begin
            tick_next = tick_inc;
            if (gap) begin
                res_next.char_code = lookup_char;
                res_next.kind      = (lookup_char != '0) ? EV_CHAR : EV_UNKNOWN;
                sym_bits_next      = '0;
                sym_len_next       = '0;
                too_long_next      = 1'b0;
                closed_next        = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_reg     <= '0;
            sym_bits_reg <= '0;
            sym_len_reg  <= '0;
            too_long_reg <= 1'b0;
            key_down_reg <= 1'b0;
            closed_reg   <= 1'b0;
        end else if (in_fire) begin
            tick_reg     <= tick_next;
            sym_bits_reg <= sym_bits_next;
            sym_len_reg  <= sym_len_next;
            too_long_reg <= too_long_next;
            key_down_reg <= key_down_next;
            closed_reg   <= closed_next;
        end
    end

    // output register with skid entry
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (out_fire) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (in_fire) begin
            if (!out_valid_reg || out_fire) begin
                out_valid_reg <= 1'b1;
            end else begin
                skid_valid_reg <= 1'b1;
            end
        end else if (out_fire) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (out_fire) begin
                out_reg <= skid_reg;
            end
        end else if (in_fire) begin
            if (!out_valid_reg || out_fire) begin
                out_reg <= res_next;
            end else begin
                skid_reg <= res_next;
            end
        end
    end

    a_skid_implies_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held without a result in the output register");

    a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        sym_len_reg <= SYM_LEN_W'(MAX_SYMBOLS))
        else $error("symbol length beyond limit");

    a_too_long_full: assert property (@(posedge aclk) disable iff (!aresetn)
        too_long_reg |-> (sym_len_reg == SYM_LEN_W'(MAX_SYMBOLS)))
        else $error("too-long flag set with symbol register not full");

    a_closed_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        closed_reg |-> (sym_len_reg == '0 && !too_long_reg && !key_down_reg))
        else $error("closed word still holds symbols or key is down");

    a_char_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> ((out_reg.kind == EV_CHAR) == (out_reg.char_code != '0)))
        else $error("character code and event kind disagree");

endmodule

/* rtl/core/mkd_char_rom.sv */
// code table: symbol pattern and length to ascii letter or digit
// depends on mkd_pkg
module mkd_char_rom import mkd_pkg::*; #(
    parameter int MAX_SYMBOLS = MAX_SYMBOLS_DEFAULT
) (
    input  logic [SYM_LEN_W-1:0]   sym_len,
    input  logic [MAX_SYMBOLS-1:0] sym_bits,
    output logic [CHAR_W-1:0]      char_code
);

    logic       upper_zero;
    logic [4:0] low_bits;

    assign upper_zero = ((sym_bits >> 5) == '0);
    assign low_bits   = sym_bits[4:0];

    always_comb begin
        char_code = '0;
        if (upper_zero) begin
            case ({sym_len, low_bits})
                {3'd2, 5'd1}:  char_code = 7'h41;
                {3'd4, 5'd8}:  char_code = 7'h42;
                {3'd4, 5'd10}: char_code = 7'h43;
                {3'd3, 5'd4}:  char_code = 7'h44;
                {3'd1, 5'd0}:  char_code = 7'h45;
                {3'd4, 5'd2}:  char_code = 7'h46;
                {3'd3, 5'd6}:  char_code = 7'h47;
                {3'd4, 5'd0}:  char_code = 7'h48;
                {3'd2, 5'd0}:  char_code = 7'h49;
                {3'd4, 5'd7}:  char_code = 7'h4A;
                {3'd3, 5'd5}:  char_code = 7'h4B;
                {3'd4, 5'd4}:  char_code = 7'h4C;
                {3'd2, 5'd3}:  char_code = 7'h4D;
                {3'd2, 5'd2}:  char_code = 7'h4E;
                {3'd3, 5'd7}:  char_code = 7'h4F;
                {3'd4, 5'd6}:  char_code = 7'h50;
                {3'd4, 5'd13}: char_code = 7'h51;
                {3'd3, 5'd2}:  char_code = 7'h52;
                {3'd3, 5'd0}:  char_code = 7'h53;
                {3'd1, 5'd1}:  char_code = 7'h54;
                {3'd3, 5'd1}:  char_code = 7'h55;
                {3'd4, 5'd1}:  char_code = 7'h56;
                {3'd3, 5'd3}:  char_code = 7'h57;
                {3'd4, 5'd9}:  char_code = 7'h58;
                {3'd4, 5'd11}: char_code = 7'h59;
                {3'd4, 5'd12}: char_code = 7'h5A;
                {3'd5, 5'd15}: char_code = 7'h31;
                {3'd5, 5'd7}:  char_code = 7'h32;
                {3'd5, 5'd3}:  char_code = 7'h33;
                {3'd5, 5'd1}:  char_code = 7'h34;
                {3'd5, 5'd0}:  char_code = 7'h35;
                {3'd5, 5'd16}: char_code = 7'h36;
                {3'd5, 5'd24}: char_code = 7'h37;
                {3'd5, 5'd28}: char_code = 7'h38;
                {3'd5, 5'd30}: char_code = 7'h39;
                {3'd5, 5'd31}: char_code = 7'h30;
                default:       char_code = '0;
            endcase
        end
    end

endmodule
